// ===== rtl/core/rotating_priority_crossbar_unit_macros.svh =====
// assertion macros for the rotating priority crossbar unit
// expects clk and rst_n in the scope where a macro is used
`ifndef ROTATING_PRIORITY_CROSSBAR_UNIT_MACROS_SVH
`define ROTATING_PRIORITY_CROSSBAR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RPC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpc assertion failed");
`define RPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpc assertion failed");
`else
`define RPC_ASSERT_SAME(name, ante, cons)
`define RPC_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ===== rtl/core/rpc_pkg.sv =====
// shared types and fixed field widths of the rotating priority crossbar
// no dependencies
package rpc_pkg;

    localparam int REQ_MASK_W = 4;
    localparam int REQ_DATA_W = 64;

    // routing dimension held in the config register
    typedef enum logic
    {
        DIM_ROW = 1'b0,
        DIM_COL = 1'b1
    } rpc_dim_t;

    // stage load enables shared by all lanes
    typedef struct packed
    {
        logic en1;
        logic en2;
        logic en3;
    } rpc_adv_t;

endpackage

// ===== rtl/core/rpc_if.sv =====
// request and result channel interfaces of the rotating priority crossbar
// depends on rpc_pkg
interface rpc_req_if import rpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_MASK_W-1:0] request_valid;
    logic [REQ_DATA_W-1:0] request_ids;
    logic [REQ_DATA_W-1:0] request_values;
    logic [REQ_MASK_W-1:0] output_full;

    modport source (output valid, request_valid, request_ids, request_values, output_full,
                    input ready);
    modport sink (input valid, request_valid, request_ids, request_values, output_full,
                  output ready);
endinterface

interface rpc_res_if import rpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_MASK_W-1:0] grant_mask;
    logic [REQ_MASK_W-1:0] out_valid;
    logic [REQ_DATA_W-1:0] out_ids;
    logic [REQ_DATA_W-1:0] out_values;

    modport source (output valid, grant_mask, out_valid, out_ids, out_values, input ready);
    modport sink (input valid, grant_mask, out_valid, out_ids, out_values, output ready);
endinterface

// ===== rtl/core/rpc_lane.sv =====
// one routing lane: destination port of one input port's id, three stages
// depends on rpc_pkg
module rpc_lane import rpc_pkg::*;
#(
    parameter int PORTS   = 4,
    parameter int COLUMNS = 4,
    parameter int NODES   = 16,
    parameter int ID_BITS = 16
)
(
    input  logic               clk,
    input  rpc_adv_t           adv,
    input  rpc_dim_t           dim_sel,
    input  logic [ID_BITS-1:0] id,
    output logic [PORTS-1:0]   dest_hot
);

    localparam int NW  = $clog2(NODES);
    localparam int CW  = $clog2(COLUMNS);
    localparam int MW  = ID_BITS + 1;
    localparam int XW  = ID_BITS + 9;
    localparam int K_N = ID_BITS + NW;
    localparam int K_C = ID_BITS + CW;
    localparam int K_R = NW + CW;
    localparam longint unsigned M_N = ((64'd1 << K_N) + NODES - 1) / NODES;
    localparam longint unsigned M_C = ((64'd1 << K_C) + COLUMNS - 1) / COLUMNS;
    localparam longint unsigned M_R = ((64'd1 << K_R) + COLUMNS - 1) / COLUMNS;
    localparam logic [MW-1:0] MN_C = MW'(M_N);
    localparam logic [MW-1:0] MC_C = MW'(M_C);
    localparam logic [NW:0]   MR_C = (NW + 1)'(M_R);

    logic [ID_BITS-1:0]       id1_reg;
    logic [ID_BITS-1:0]       qn_reg;
    logic [ID_BITS-1:0]       qc_reg;
    logic [ID_BITS-1:0]       qn_next;
    logic [ID_BITS-1:0]       qc_next;
    logic [NW-1:0]            rn_reg;
    logic [CW-1:0]            col_reg;
    logic [NW-1:0]            rn_next;
    logic [CW-1:0]            col_next;
    logic [PORTS-1:0]         hot_reg;
    logic [PORTS-1:0]         hot_next;
    logic [ID_BITS+MW-1:0]    prod_n;
    logic [ID_BITS+MW-1:0]    prod_c;
    logic [XW-1:0]            rem_n_full;
    logic [XW-1:0]            rem_c_full;
    logic [2*NW:0]            prod_r;
    logic [NW-1:0]            row;

    // quotients by reciprocal multiply, exact over the id range
    always_comb
    begin
        prod_n  = (ID_BITS + MW)'(id) * (ID_BITS + MW)'(MN_C);
        prod_c  = (ID_BITS + MW)'(id) * (ID_BITS + MW)'(MC_C);
        qn_next = ID_BITS'(prod_n >> K_N);
        qc_next = ID_BITS'(prod_c >> K_C);
    end

    // remainders
    always_comb
    begin
        rem_n_full = XW'(id1_reg) - XW'(qn_reg) * XW'(NODES);
        rem_c_full = XW'(id1_reg) - XW'(qc_reg) * XW'(COLUMNS);
        rn_next    = rem_n_full[NW-1:0];
        col_next   = rem_c_full[CW-1:0];
    end

    // row index, then one-hot destination
    always_comb
    begin
        prod_r = (2 * NW + 1)'(rn_reg) * (2 * NW + 1)'(MR_C);
        row    = NW'(prod_r >> K_R);
        for (int q = 0; q < PORTS; q++)
        begin
            if (dim_sel == DIM_COL)
                hot_next[q] = (32'(col_reg) == 32'(q));
            else
                hot_next[q] = (32'(row) == 32'(q));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.en1)
        begin
            id1_reg <= id;
            qn_reg  <= qn_next;
            qc_reg  <= qc_next;
        end
        if (adv.en2)
        begin
            rn_reg  <= rn_next;
            col_reg <= col_next;
        end
        if (adv.en3)
            hot_reg <= hot_next;
    end

    assign dest_hot = hot_reg;

endmodule

// ===== rtl/core/rpc_merge.sv =====
// merge stage: rotating priority pick per output port over all lanes
// depends on rpc_pkg
module rpc_merge import rpc_pkg::*;
#(
    parameter int PORTS      = 4,
    parameter int ID_BITS    = 16,
    parameter int VALUE_BITS = 16
)
(
    input  logic [PORTS-1:0]              req_valid,
    input  logic [PORTS-1:0][PORTS-1:0]   dest_hot,
    input  logic [PORTS-1:0]              out_full,
    input  logic [$clog2(PORTS)-1:0]      ptr,
    input  logic [PORTS*ID_BITS-1:0]      ids,
    input  logic [PORTS*VALUE_BITS-1:0]   vals,
    output logic [PORTS-1:0]              grant,
    output logic [PORTS-1:0]              ovalid,
    output logic [PORTS*ID_BITS-1:0]      oids,
    output logic [PORTS*VALUE_BITS-1:0]   ovals
);

    localparam int PW = $clog2(PORTS);

    always_comb
    begin
        logic [PW:0]   sum;
        logic [PW-1:0] sel;
        logic          hit;
        grant  = '0;
        ovalid = '0;
        oids   = '0;
        ovals  = '0;
        sum    = '0;
        sel    = '0;
        hit    = 1'b0;
        for (int q = 0; q < PORTS; q++)
        begin
            hit = 1'b0;
            if (!out_full[q])
            begin
                for (int k = 0; k < PORTS; k++)
                begin
                    // scan from the pointer, wrapping past the last port
                    sum = (PW + 1)'(ptr) + (PW + 1)'(k);
                    if (sum >= (PW + 1)'(PORTS))
                        sum = sum - (PW + 1)'(PORTS);
                    sel = sum[PW-1:0];
                    if (!hit && req_valid[sel] && dest_hot[sel][q])
                    begin
                        hit                             = 1'b1;
                        grant[sel]                      = 1'b1;
                        ovalid[q]                       = 1'b1;
                        oids[q*ID_BITS +: ID_BITS]      = ids[sel*ID_BITS +: ID_BITS];
                        ovals[q*VALUE_BITS +: VALUE_BITS] =
                            vals[sel*VALUE_BITS +: VALUE_BITS];
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/rotating_priority_crossbar_unit.sv =====
// rotating priority crossbar unit: one switch allocation step of a 2-d noc router
// depends on rpc_pkg, rpc_if, rpc_lane, rpc_merge and the assertion macros
//
// usage
//  - req channel: one request per accepted handshake, carrying a valid bit, id and
//    value for every input port plus a full flag for every output port
//  - res channel: exactly one result per request, in order: grant mask per input,
//    forwarded valid, id and value per output port; unused entries read zero
//  - cfg_we / cfg_wdata write dimension_select (0 row, 1 column); write only while
//    no request is in flight
//  - a request passes three lane stages, then the merge into the output register
//  - throughput: one request per cycle while res is not stalled, set by the lane pipeline
//  - the priority pointer moves by one on every accepted request, wrapping at PORTS
//  - reset clears the pointer, the config register and all stage valids; the block
//    takes a request in the first cycle after reset
//  - a stalled result holds in the output register; stages behind it keep filling
//    until the pipeline is full, then req.ready drops
`include "rotating_priority_crossbar_unit_macros.svh"
module rotating_priority_crossbar_unit import rpc_pkg::*;
#(
    parameter int PORTS      = 4,
    parameter int COLUMNS    = 4,
    parameter int NODES      = 16,
    parameter int ID_BITS    = 16,
    parameter int VALUE_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    rpc_req_if.sink      req,
    rpc_res_if.source    res,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);

    localparam int PW = $clog2(PORTS);
    localparam int IW = PORTS * ID_BITS;
    localparam int VW = PORTS * VALUE_BITS;

    // pipeline control
    logic           en1;
    logic           en2;
    logic           en3;
    logic           en4;
    logic           accept;
    rpc_adv_t       adv;
    logic [3:1]     vld_reg;
    logic [3:1]     vld_next;
    logic           out_vld_reg;
    logic           out_vld_next;
    logic [PW-1:0]  ptr_reg;
    logic [PW-1:0]  ptr_next;
    rpc_dim_t       dim_reg;
    rpc_dim_t       dim_next;

    // request payload carried alongside the lanes
    logic [PORTS-1:0] rv_reg   [1:3];
    logic [PORTS-1:0] full_reg [1:3];
    logic [PW-1:0]    pst_reg  [1:3];
    logic [IW-1:0]    ids_reg  [1:3];
    logic [VW-1:0]    vals_reg [1:3];

    // lane and merge results
    logic [PORTS-1:0][PORTS-1:0] hot;
    logic [PORTS-1:0]            m_grant;
    logic [PORTS-1:0]            m_ovalid;
    logic [IW-1:0]               m_oids;
    logic [VW-1:0]               m_ovals;

    // output register
    logic [PORTS-1:0] grant_reg;
    logic [PORTS-1:0] ovalid_reg;
    logic [IW-1:0]    oids_reg;
    logic [VW-1:0]    ovals_reg;

    // a stage loads when it is empty or its content moves on
    assign en4    = !out_vld_reg || res.ready;
    assign en3    = !vld_reg[3] || en4;
    assign en2    = !vld_reg[2] || en3;
    assign en1    = !vld_reg[1] || en2;
    assign accept = req.valid && en1;

    assign req.ready = en1;

    always_comb
    begin
        adv.en1 = en1;
        adv.en2 = en2;
        adv.en3 = en3;
    end

    always_comb
    begin
        vld_next[1]  = en1 ? req.valid  : vld_reg[1];
        vld_next[2]  = en2 ? vld_reg[1] : vld_reg[2];
        vld_next[3]  = en3 ? vld_reg[2] : vld_reg[3];
        out_vld_next = en4 ? vld_reg[3] : out_vld_reg;
        // pointer steps once per request, wrapping at the last port
        ptr_next     = ptr_reg;
        if (accept)
            ptr_next = (ptr_reg == PW'(PORTS - 1)) ? '0 : ptr_reg + 1'b1;
        dim_next     = cfg_we ? rpc_dim_t'(cfg_wdata) : dim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
            ptr_reg     <= '0;
            dim_reg     <= DIM_ROW;
        end
        else
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
            ptr_reg     <= ptr_next;
            dim_reg     <= dim_next;
        end
    end

    // payload stages, no reset needed
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            rv_reg[1]   <= req.request_valid[PORTS-1:0];
            full_reg[1] <= req.output_full[PORTS-1:0];
            pst_reg[1]  <= ptr_reg;
            ids_reg[1]  <= req.request_ids[IW-1:0];
            vals_reg[1] <= req.request_values[VW-1:0];
        end
        if (en2)
        begin
            rv_reg[2]   <= rv_reg[1];
            full_reg[2] <= full_reg[1];
            pst_reg[2]  <= pst_reg[1];
            ids_reg[2]  <= ids_reg[1];
            vals_reg[2] <= vals_reg[1];
        end
        if (en3)
        begin
            rv_reg[3]   <= rv_reg[2];
            full_reg[3] <= full_reg[2];
            pst_reg[3]  <= pst_reg[2];
            ids_reg[3]  <= ids_reg[2];
            vals_reg[3] <= vals_reg[2];
        end
        if (en4)
        begin
            grant_reg  <= m_grant;
            ovalid_reg <= m_ovalid;
            oids_reg   <= m_oids;
            ovals_reg  <= m_ovals;
        end
    end

    // one routing lane per input port
    for (genvar p = 0; p < PORTS; p++)
    begin : g_lane
        rpc_lane #(
            .PORTS   (PORTS),
            .COLUMNS (COLUMNS),
            .NODES   (NODES),
            .ID_BITS (ID_BITS)
        ) u_lane (
            .clk      (clk),
            .adv      (adv),
            .dim_sel  (dim_reg),
            .id       (req.request_ids[p*ID_BITS +: ID_BITS]),
            .dest_hot (hot[p])
        );
    end

    // per-output arbitration across the lanes
    rpc_merge #(
        .PORTS      (PORTS),
        .ID_BITS    (ID_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_merge (
        .req_valid (rv_reg[3]),
        .dest_hot  (hot),
        .out_full  (full_reg[3]),
        .ptr       (pst_reg[3]),
        .ids       (ids_reg[3]),
        .vals      (vals_reg[3]),
        .grant     (m_grant),
        .ovalid    (m_ovalid),
        .oids      (m_oids),
        .ovals     (m_ovals)
    );

    // result channel, entries above PORTS read zero
    assign res.valid      = out_vld_reg;
    assign res.grant_mask = REQ_MASK_W'(grant_reg);
    assign res.out_valid  = REQ_MASK_W'(ovalid_reg);
    assign res.out_ids    = REQ_DATA_W'(oids_reg);
    assign res.out_values = REQ_DATA_W'(ovals_reg);

    // only requesting ports are granted
    `RPC_ASSERT_SAME(a_grant_requested, vld_reg[3], (m_grant & ~rv_reg[3]) == '0)
    // a full output never forwards
    `RPC_ASSERT_SAME(a_full_blocks, vld_reg[3], (m_ovalid & full_reg[3]) == '0)
    // each grant feeds exactly one output
    `RPC_ASSERT_SAME(a_grant_count, res.valid,
        $countones(res.grant_mask) == $countones(res.out_valid))
    // pointer holds without a request and moves with one
    `RPC_ASSERT_NEXT(a_ptr_hold, !accept, $stable(ptr_reg))
    `RPC_ASSERT_NEXT(a_ptr_move, accept, ptr_reg != $past(ptr_reg))

endmodule
